@@ design/kvlt_pkg.sv @@
// Shared types and constants for the key/value list table.
`default_nettype none

package kvlt_pkg;

    // Field widths
    localparam int KEY_W = 32;
    localparam int VAL_W = 32;

    // Operation codes; code 3 is unused and leaves the table alone
    typedef logic [1:0] t_opcode;
    localparam t_opcode OP_PUT = 2'd0;
    localparam t_opcode OP_GET = 2'd1;
    localparam t_opcode OP_DEL = 2'd2;

    // Controller states
    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;   // latch the operation and register the key compares
        logic exec;   // apply the operation and load the result register
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic out_free;   // result register can take a new result this cycle
    } t_dp_status;

endpackage

`default_nettype wire

@@ design/kvlt_ctrl.sv @@
// Controller state machine for the key/value list table.
`default_nettype none

module kvlt_ctrl (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_in_valid,
    output logic                   o_in_stall,
    input  kvlt_pkg::t_dp_status   i_status,
    output kvlt_pkg::t_dp_cmd      o_cmd
);
    import kvlt_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_stall = 1'b1;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                // hold the input off while reset is applied
                o_in_stall = !i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                // hold until the result register frees up
                if (i_status.out_free) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ design/kvlt_datapath.sv @@
// Entry storage, key compare, update/shift logic and result register.
`default_nettype none

module kvlt_datapath #(
    parameter int DEPTH = 16
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  kvlt_pkg::t_dp_cmd           i_cmd,
    output kvlt_pkg::t_dp_status        o_status,
    input  kvlt_pkg::t_opcode           i_opcode,
    input  wire [kvlt_pkg::KEY_W-1:0]   i_key,
    input  wire [kvlt_pkg::VAL_W-1:0]   i_value_in,
    input  wire                         i_out_stall,
    output logic                        o_out_valid,
    output logic                        o_hit,
    output logic [kvlt_pkg::VAL_W-1:0]  o_value_out,
    output logic                        o_rejected_full
);
    import kvlt_pkg::*;

    localparam int                CNT_W   = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0]  DEPTH_C = CNT_W'(DEPTH);

    // Entry row
    logic [KEY_W-1:0] r_keys [DEPTH];
    logic [VAL_W-1:0] r_vals [DEPTH];
    logic [CNT_W-1:0] r_count;

    // Operation held between compare and execute
    t_opcode          r_op;
    logic [KEY_W-1:0] r_key;
    logic [VAL_W-1:0] r_val;
    logic [DEPTH-1:0] r_match;

    // Result register
    logic             r_out_valid;
    logic             r_hit;
    logic [VAL_W-1:0] r_value_out;
    logic             r_rej;

    logic [DEPTH-1:0] w_cmp;
    logic [DEPTH-1:0] w_before;
    logic [DEPTH-1:0] w_first;
    logic [DEPTH-1:0] w_at_after;
    logic [KEY_W-1:0] w_next_key [DEPTH];
    logic [VAL_W-1:0] w_next_val [DEPTH];
    logic [VAL_W-1:0] w_found;
    logic             w_op_ok;
    logic             w_hit;
    logic             w_full;
    logic             w_put_new;
    logic             w_put_rej;
    logic             w_del;

    for (genvar g = 0; g < DEPTH; g++) begin : g_entry
        localparam logic [DEPTH-1:0] LOW_MASK = (DEPTH'(1) << g) - DEPTH'(1);

        assign w_cmp[g]      = (r_keys[g] == i_key) && (CNT_W'(g) < r_count);
        assign w_before[g]   = |(r_match & LOW_MASK);
        assign w_first[g]    = r_match[g] & ~w_before[g];
        assign w_at_after[g] = r_match[g] | w_before[g];

        if (g < DEPTH - 1) begin : g_shift
            // pull the next entry down over the deleted one and its followers
            assign w_next_key[g] = r_keys[g+1];
            assign w_next_val[g] = r_vals[g+1];
        end else begin : g_last
            // the last slot keeps its contents
            assign w_next_key[g] = r_keys[g];
            assign w_next_val[g] = r_vals[g];
        end

        always_ff @(posedge i_clk) begin
            if (i_cmd.exec) begin
                if (w_del && w_at_after[g]) begin
                    r_keys[g] <= w_next_key[g];
                    r_vals[g] <= w_next_val[g];
                end
                if (r_op == OP_PUT && w_first[g]) begin
                    r_vals[g] <= r_val;
                end
                if (w_put_new && CNT_W'(g) == r_count) begin
                    r_keys[g] <= r_key;
                    r_vals[g] <= r_val;
                end
            end
        end
    end

    always_comb begin
        w_found = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_found = w_found | (r_vals[i] & {VAL_W{w_first[i]}});
        end
    end

    assign w_op_ok   = (r_op == OP_PUT) || (r_op == OP_GET) || (r_op == OP_DEL);
    assign w_hit     = w_op_ok && (|r_match);
    assign w_full    = (r_count == DEPTH_C);
    assign w_put_new = (r_op == OP_PUT) && !w_hit && !w_full;
    assign w_put_rej = (r_op == OP_PUT) && !w_hit && w_full;
    assign w_del     = (r_op == OP_DEL) && w_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                if (w_put_new) begin
                    r_count <= r_count + CNT_W'(1);
                end else if (w_del) begin
                    r_count <= r_count - CNT_W'(1);
                end
            end
            if (i_cmd.exec) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_opcode;
            r_key   <= i_key;
            r_val   <= i_value_in;
            r_match <= w_cmp;
        end
        if (i_cmd.exec) begin
            r_hit       <= w_hit;
            r_value_out <= (r_op == OP_GET && w_hit) ? w_found : '0;
            r_rej       <= w_put_rej;
        end
    end

    assign o_status.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid       = r_out_valid;
    assign o_hit             = r_hit;
    assign o_value_out       = r_value_out;
    assign o_rejected_full   = r_rej;

endmodule

`default_nettype wire

@@ design/key_value_list_table_core.sv @@
// Top level of the key/value list table: controller, datapath and checks.
`default_nettype none

// Channel   Direction  Handshake                Payload
// input     in         i_in_valid / o_in_stall  i_opcode, i_key, i_value_in
// result    out        o_out_valid / i_out_stall o_hit, o_value_out, o_rejected_full
//
// Each operation runs a load step that compares the key against all valid
// entries in parallel, then an execute step that applies the update or shift
// and loads the result; it waits while the result register is full and stalled.
// Reset is synchronous and active low; it empties the table (count to zero),
// drops any pending result and holds the input stalled while applied.
// Entry contents are not cleared.

module key_value_list_table_core #(
    parameter int DEPTH = 16
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    // input channel
    input  wire                         i_in_valid,
    output logic                        o_in_stall,
    input  kvlt_pkg::t_opcode           i_opcode,
    input  wire [kvlt_pkg::KEY_W-1:0]   i_key,
    input  wire [kvlt_pkg::VAL_W-1:0]   i_value_in,
    // result channel
    output logic                        o_out_valid,
    input  wire                         i_out_stall,
    output logic                        o_hit,
    output logic [kvlt_pkg::VAL_W-1:0]  o_value_out,
    output logic                        o_rejected_full
);
    import kvlt_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // Sequence load and execute of one operation at a time
    kvlt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Hold the entries, compare keys, update or shift, register the result
    kvlt_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_opcode        (i_opcode),
        .i_key           (i_key),
        .i_value_in      (i_value_in),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_hit           (o_hit),
        .o_value_out     (o_value_out),
        .o_rejected_full (o_rejected_full)
    );

    // An accepted transfer makes the block busy for the execute cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after accepted transfer");

    // Executing an operation always presents a result in the next cycle
    a_result_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.exec |=> o_out_valid)
        else $error("no result after execute");

    // A rejected put never reports a hit or a value
    a_reject_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_rejected_full) |-> (!o_hit && o_value_out == '0))
        else $error("rejected put carries hit or value");

    // Load and execute never overlap
    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.load && w_cmd.exec))
        else $error("load and execute in the same cycle");

endmodule

`default_nettype wire

@@ tb/key_value_list_table_core_tb.sv @@
// Self-checking testbench for the key/value list table: directed and random operations.
`timescale 1ns / 100ps

localparam int TABLE_DEPTH = 16;

// Opcode 3 has no meaning and must leave the table alone
localparam kvlt_pkg::t_opcode OP_UNUSED = 2'd3;

typedef struct packed {
    logic                      hit;
    logic [kvlt_pkg::VAL_W-1:0] value;
    logic                      full;
} t_kv_answer;

// Shadow copy of the table plus the answers still owed by the block
class kv_scoreboard;
    logic [kvlt_pkg::KEY_W-1:0] keys [TABLE_DEPTH];
    logic [kvlt_pkg::VAL_W-1:0] vals [TABLE_DEPTH];
    int                         count = 0;
    t_kv_answer                 answers [$];
    int                         errors = 0;

    // Apply one accepted operation to the shadow table and queue its answer
    function void note_op(kvlt_pkg::t_opcode op, logic [kvlt_pkg::KEY_W-1:0] key,
                          logic [kvlt_pkg::VAL_W-1:0] value);
        int         slot;
        t_kv_answer ans;
        slot = -1;
        ans  = '0;
        for (int i = 0; i < count; i++) begin
            if (slot < 0 && keys[i] == key) slot = i;
        end
        if (op != OP_UNUSED) ans.hit = (slot >= 0);
        case (op)
            kvlt_pkg::OP_PUT: begin
                if (slot >= 0) begin
                    vals[slot] = value;
                end else if (count < TABLE_DEPTH) begin
                    keys[count] = key;
                    vals[count] = value;
                    count++;
                end else begin
                    ans.full = 1'b1;
                end
            end
            kvlt_pkg::OP_GET: begin
                if (slot >= 0) ans.value = vals[slot];
            end
            kvlt_pkg::OP_DEL: begin
                if (slot >= 0) begin
                    for (int i = slot; i < count - 1; i++) begin
                        keys[i] = keys[i + 1];
                        vals[i] = vals[i + 1];
                    end
                    count--;
                end
            end
            default: ;
        endcase
        answers.push_back(ans);
    endfunction

    // Compare one result transfer against the oldest owed answer
    function void check_result(logic hit, logic [kvlt_pkg::VAL_W-1:0] value, logic full);
        t_kv_answer want;
        if (answers.size() == 0) begin
            errors++;
            $display("%0t: unexpected result: hit %0b value %h full %0b",
                     $time, hit, value, full);
            return;
        end
        want = answers.pop_front();
        if (hit !== want.hit) begin
            errors++;
            $display("%0t: hit expected %0b actual %0b", $time, want.hit, hit);
        end
        if (value !== want.value) begin
            errors++;
            $display("%0t: value_out expected %h actual %h", $time, want.value, value);
        end
        if (full !== want.full) begin
            errors++;
            $display("%0t: rejected_full expected %0b actual %0b", $time, want.full, full);
        end
    endfunction

    function int pending();
        return answers.size();
    endfunction
endclass

module key_value_list_table_core_tb;
    import kvlt_pkg::*;

    localparam int HOLD_CYCLES  = 300;   // length of the long receiver hold-off
    localparam int KEY_POOL     = 20;    // a few more keys than slots, so the table fills
    localparam int RANDOM_ITEMS = 2000;
    localparam int SEGMENTS     = 8;
    localparam int PRESSURE_SEG = 4;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    t_opcode            i_opcode = OP_PUT;
    logic [KEY_W-1:0]   i_key = '0;
    logic [VAL_W-1:0]   i_value_in = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic               o_hit;
    logic [VAL_W-1:0]   o_value_out;
    logic               o_rejected_full;

    // Idle and stall odds in percent; changed by the main sequence per segment
    int                 idle_pct = 0;
    int                 stall_pct = 0;
    int                 hold_requests = 0;
    int                 holds_done = 0;

    logic [KEY_W-1:0]   key_pool [KEY_POOL];
    kv_scoreboard       sb;

    key_value_list_table_core #(
        .DEPTH(TABLE_DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_opcode       (i_opcode),
        .i_key          (i_key),
        .i_value_in     (i_value_in),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_hit          (o_hit),
        .o_value_out    (o_value_out),
        .o_rejected_full(o_rejected_full)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Watch both channels; values read here are the ones settled before the edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) sb.note_op(i_opcode, i_key, i_value_in);
            if (o_out_valid && !i_out_stall) sb.check_result(o_hit, o_value_out, o_rejected_full);
        end
    end

    // Receiver: random stalls, or one long hold-off when the main sequence asks
    initial begin : receiver
        forever begin
            @(posedge i_clk);
            if (holds_done != hold_requests) begin
                holds_done++;
                i_out_stall <= 1'b1;
                // keep stalling; the sender goes on offering so the block backs up
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
            end else begin
                i_out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    // Offer one transfer, idling first at random; return at the accepting edge
    task automatic send_op(t_opcode op, logic [KEY_W-1:0] key, logic [VAL_W-1:0] value);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode   <= op;
        i_key      <= key;
        i_value_in <= value;
        // hold the payload steady until the block takes it
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Draw one operation, mostly on pool keys so hits, updates and deletes happen
    task automatic send_random(int put_pct, int del_pct);
        int              roll;
        t_opcode         op;
        logic [KEY_W-1:0] key;
        roll = $urandom_range(99);
        if (roll < put_pct)                op = OP_PUT;
        else if (roll < put_pct + del_pct) op = OP_DEL;
        else if (roll < 95)                op = OP_GET;
        else                               op = OP_UNUSED;
        if ($urandom_range(99) < 85) key = key_pool[$urandom_range(KEY_POOL - 1)];
        else                         key = $urandom;
        send_op(op, key, $urandom);
    endtask

    // Main sequence
    initial begin : stimulus
        int phase_idle  [4];
        int phase_stall [4];
        phase_idle  = '{0, 80, 0, 27};
        phase_stall = '{0, 0, 80, 27};
        sb = new();
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < KEY_POOL; i++) key_pool[i] = $urandom;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty table misses, extreme keys and values, update, unused code
        send_op(OP_GET, 32'h0000_0000, 32'hFFFF_FFFF);
        send_op(OP_DEL, 32'h0000_0000, 32'hFFFF_FFFF);
        send_op(OP_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
        send_op(OP_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
        send_op(OP_GET, 32'h0000_0000, 32'h5A5A_5A5A);
        send_op(OP_PUT, 32'h0000_0000, 32'h1234_5678);
        send_op(OP_UNUSED, 32'h0000_0000, 32'hFFFF_FFFF);
        send_op(OP_GET, 32'h0000_0000, 32'h0000_0000);
        // delete the first entry so the rest shifts down
        send_op(OP_DEL, 32'h0000_0000, 32'hA5A5_A5A5);
        // fill the table to the last slot
        for (int i = 0; i < TABLE_DEPTH - 1; i++) begin
            send_op(OP_PUT, 32'hA5A5_0000 + i, 32'h0F0F_0000 + i);
        end
        // full table: new key is turned away, existing key still updates
        send_op(OP_PUT, 32'h8000_0001, 32'hDEAD_BEEF);
        send_op(OP_PUT, 32'hA5A5_0007, 32'hCAFE_F00D);
        send_op(OP_DEL, 32'hA5A5_0003, 32'h0000_0000);
        send_op(OP_GET, 32'hA5A5_0007, 32'h0000_0000);

        // Random: rotate through idle and stall patterns, alternate fill-heavy and drain-heavy mixes
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            idle_pct  = phase_idle[seg % 4];
            stall_pct = phase_stall[seg % 4];
            if (seg == PRESSURE_SEG) hold_requests++;
            repeat (RANDOM_ITEMS / SEGMENTS) begin
                if (seg % 2 == 0) send_random(45, 20);
                else              send_random(25, 40);
            end
        end
        i_in_valid <= 1'b0;

        // Drain, then keep watching so that any stray result shows
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("** key_value_list_table_core: PASSED **");
        end else begin
            $display("** key_value_list_table_core: FAILED **");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("** key_value_list_table_core: FAILED **");
        $finish;
    end

endmodule
